FILE: design/open_address_hash_table_core_macros.svh
// assertion macros for the open address hash table core
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OAHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define OAHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OAHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define OAHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/oaht_pkg.sv
// shared types and constants of the open address hash table
`default_nettype none
package oaht_pkg;
   localparam int KEY_W      = 64;
   localparam int LEN_W      = 4;
   localparam int VALUE_W    = 32;
   localparam int HASH_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int CMD_W      = 2;
   localparam int SLOT_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int KEY_MAX_BYTES = KEY_W / BYTE_W;
   localparam int BYTE_IDX_W = $clog2(KEY_MAX_BYTES);

   localparam logic [HASH_W-1:0] HASH_SEED = 32'd6251;
   localparam int HASH_SHIFT  = 5;
   localparam int PROBE_LIMIT = 500;
   localparam int STEP_W      = $clog2(PROBE_LIMIT);

   // remainder unit: bits folded per cycle
   localparam int RED_BITS   = 4;
   localparam int RED_ROUNDS = HASH_W / RED_BITS;
   localparam int RED_CNT_W  = $clog2(RED_ROUNDS);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic                in_use;
      logic                alive;
      logic [HASH_W-1:0]   hash;
      logic [LEN_W-1:0]    key_len;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } slot_rec_type;

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_BYTES,
      HS_REDUCE
   } hash_state_type;

   typedef enum logic [2:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_HASH,
      CS_CHECK,
      CS_REPLY
   } core_state_type;
endpackage
`default_nettype wire

FILE: design/oaht_channels.sv
// request and response channel interfaces
`default_nettype none
interface oaht_req_if;
   import oaht_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic [KEY_W-1:0]           key_bytes;
   logic [LEN_W-1:0]           key_length;
   logic signed [VALUE_W-1:0]  new_value;
   modport source (output valid, command, key_bytes, key_length, new_value, input ready);
   modport sink (input valid, command, key_bytes, key_length, new_value, output ready);
endinterface

interface oaht_rsp_if;
   import oaht_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  found_value;
   logic [SLOT_W-1:0]          slot;
   modport source (output valid, status, found_value, slot, input ready);
   modport sink (input valid, status, found_value, slot, output ready);
endinterface
`default_nettype wire

FILE: design/open_address_hash_table_core.sv
// open address hash table core with triangular probing
// a remainder pass finds the home slot when CAPACITY is not a power of two
// one item at a time; each probe is one read on the slot memory read port
// next request is taken the cycle after a response is registered, while it waits
// reset: synchronous; a clearing pass over every slot wipes the in-use flags
//   before the first request is taken
`default_nettype none
`include "open_address_hash_table_core_macros.svh"
module open_address_hash_table_core #(
   parameter int CAPACITY  = 256,
   parameter int KEY_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   oaht_req_if.sink    req_bus,
   oaht_rsp_if.source  rsp_bus
);
   import oaht_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [LEN_W-1:0]   LEN_CAP   = LEN_W'(KEY_BYTES);
   localparam logic [IDX_W+1:0]   CAP_FULL  = (IDX_W + 2)'(CAPACITY);
   localparam logic [IDX_W:0]     CAP_WRAP  = (IDX_W + 1)'(CAPACITY);
   localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(CAPACITY - 1);
   localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(PROBE_LIMIT - 1);

   // control state
   core_state_type        state_ff, state_in;
   logic [IDX_W-1:0]      clr_ff, clr_in;
   logic [IDX_W-1:0]      live_ff, live_in;
   logic [IDX_W-1:0]      used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // item being worked on
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [VALUE_W-1:0]    value_ff, value_in;

   // probe position, step count and step modulo capacity
   logic [IDX_W-1:0]      p_ff, p_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      stepm_ff, stepm_in;

   // finished result and output register
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [VALUE_W-1:0]    res_found_ff, res_found_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic [LEN_W-1:0]      len_sat;
   logic [KEY_W-1:0]      key_masked;
   logic                  hash_start;
   logic                  hash_done;
   logic [HASH_W-1:0]     hash_val;
   logic [IDX_W-1:0]      home;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   slot_rec_type          mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   slot_rec_type          rd_rec;
   logic                  slot_match;
   logic                  slot_free;
   logic                  at_limit;
   logic [IDX_W:0]        p_sum;
   logic [IDX_W-1:0]      p_next;
   logic [IDX_W+1:0]      used_p1;
   logic [IDX_W+1:0]      used_dbl;
   logic                  table_full;

   oaht_hash #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (key_masked),
      .key_len (len_sat),
      .done    (hash_done),
      .hash    (hash_val),
      .home    (home)
   );

   oaht_slot_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_rec)
   );

   // handshakes
   assign req_bus.ready = (state_ff == CS_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // saturate the length and drop the bytes above it
   assign len_sat = (req_bus.key_length > LEN_CAP) ? LEN_CAP : req_bus.key_length;

   always_comb begin
      for (int b = 0; b < KEY_MAX_BYTES; b++) begin
         key_masked[b*BYTE_W +: BYTE_W] = (LEN_W'(b) < len_sat) ?
            req_bus.key_bytes[b*BYTE_W +: BYTE_W] : '0;
      end
   end

   // slot compare on the record read last cycle
   assign slot_match = rd_rec.in_use && rd_rec.alive && (rd_rec.hash == hash_val) &&
                       (rd_rec.key_len == len_ff) && (rd_rec.key == key_ff);
   assign slot_free  = !rd_rec.in_use;
   assign at_limit   = (step_ff == LAST_STEP);

   // next probe: stepm stays below capacity so one wrap subtract is enough
   assign p_sum  = (IDX_W + 1)'(p_ff) + (IDX_W + 1)'(stepm_ff);
   assign p_next = (p_sum >= CAP_WRAP) ? IDX_W'(p_sum - CAP_WRAP) : p_sum[IDX_W-1:0];

   // grow limit: full when capacity <= 2 * (used + 1)
   assign used_p1    = (IDX_W + 2)'(used_ff) + (IDX_W + 2)'(1);
   assign used_dbl   = (IDX_W + 2)'(used_ff) << 1;
   assign table_full = CAP_FULL <= (used_p1 << 1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      live_in       = live_ff;
      used_in       = used_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      value_in      = value_ff;
      p_in          = p_ff;
      step_in       = step_ff;
      stepm_in      = stepm_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      hash_start    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = p_ff;
      mem_wr_data   = rd_rec;
      mem_rd_addr   = p_ff;

      case (state_ff)
         CS_CLEAR: begin
            // wipe in-use flags, one slot a cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_bus.command;
               key_in   = key_masked;
               len_in   = len_sat;
               value_in = req_bus.new_value;
               if ((req_bus.command == CMD_INSERT) ||
                   (((req_bus.command == CMD_LOOKUP) || (req_bus.command == CMD_DELETE)) &&
                    (live_ff != '0))) begin
                  hash_start = 1'b1;
                  state_in   = CS_HASH;
               end else begin
                  // empty table or unknown command
                  res_status_in = ST_NOT_FOUND;
                  res_found_in  = '0;
                  res_slot_in   = '0;
                  state_in      = CS_REPLY;
               end
            end
         end
         CS_HASH: begin
            // home slot read issued in the cycle the hash lands
            mem_rd_addr = home;
            if (hash_done) begin
               p_in     = home;
               step_in  = STEP_W'(1);
               stepm_in = IDX_W'(1);
               state_in = CS_CHECK;
            end
         end
         CS_CHECK: begin
            mem_rd_addr = p_next;
            if (slot_match || slot_free || at_limit) begin
               res_status_in = ST_NOT_FOUND;
               res_found_in  = '0;
               res_slot_in   = '0;
               state_in      = CS_REPLY;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (slot_match) begin
                        res_status_in     = ST_UPDATED;
                        res_slot_in       = SLOT_W'(p_ff);
                        mem_wr_en         = 1'b1;
                        mem_wr_data.value = value_ff;
                     end else if (table_full || !slot_free) begin
                        res_status_in = ST_FULL;
                     end else begin
                        res_status_in       = ST_INSERTED;
                        res_slot_in         = SLOT_W'(p_ff);
                        mem_wr_en           = 1'b1;
                        mem_wr_data.in_use  = 1'b1;
                        mem_wr_data.alive   = 1'b1;
                        mem_wr_data.hash    = hash_val;
                        mem_wr_data.key_len = len_ff;
                        mem_wr_data.key     = key_ff;
                        mem_wr_data.value   = value_ff;
                        live_in             = live_ff + IDX_W'(1);
                        used_in             = used_ff + IDX_W'(1);
                     end
                  end
                  CMD_LOOKUP: begin
                     if (slot_match) begin
                        res_status_in = ST_FOUND;
                        res_found_in  = rd_rec.value;
                        res_slot_in   = SLOT_W'(p_ff);
                     end
                  end
                  CMD_DELETE: begin
                     if (slot_match) begin
                        // tombstone: slot stays in use
                        res_status_in     = ST_DELETED;
                        res_slot_in       = SLOT_W'(p_ff);
                        mem_wr_en         = 1'b1;
                        mem_wr_data.alive = 1'b0;
                        live_in           = live_ff - IDX_W'(1);
                     end
                  end
                  default: begin
                     res_status_in = ST_NOT_FOUND;
                  end
               endcase
            end else begin
               p_in     = p_next;
               step_in  = step_ff + STEP_W'(1);
               stepm_in = (stepm_ff == LAST_SLOT) ? '0 : stepm_ff + IDX_W'(1);
            end
         end
         CS_REPLY: begin
            // move the result into the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      value_ff      <= value_in;
      p_ff          <= p_in;
      step_ff       <= step_in;
      stepm_ff      <= stepm_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.found_value = rsp_found_ff;
   assign rsp_bus.slot        = rsp_slot_ff;

   // checks
   `OAHT_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == CS_IDLE, !mem_wr_en, "slot store written while idle")
   `OAHT_ASSERT_NOW(a_live_le_used, clock, reset, 1'b1, live_ff <= used_ff, "live count above used count")
   `OAHT_ASSERT_NOW(a_used_below_half, clock, reset, 1'b1, used_dbl < CAP_FULL, "used slots reached half capacity")
   `OAHT_ASSERT_NEXT(a_accept_moves_on, clock, reset, req_accept, state_ff == CS_HASH || state_ff == CS_REPLY, "accepted transfer not taken up")
   `OAHT_ASSERT_NOW(a_hash_done_in_hash, clock, reset, hash_done, state_ff == CS_HASH, "hash finished outside hash wait")
endmodule
`default_nettype wire

FILE: design/oaht_hash.sv
// byte-serial key hash and home slot remainder unit
`default_nettype none
module oaht_hash #(
   parameter int CAPACITY = 256,
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [oaht_pkg::KEY_W-1:0]    key,
   input  logic [oaht_pkg::LEN_W-1:0]    key_len,
   output logic                          done,
   output logic [oaht_pkg::HASH_W-1:0]   hash,
   output logic [IDX_W-1:0]              home
);
   import oaht_pkg::*;

   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam logic [IDX_W:0] CAP_R = (IDX_W + 1)'(CAPACITY);
   localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(RED_ROUNDS - 1);

   hash_state_type          state_ff, state_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic [HASH_W-1:0]       h_ff, h_in;
   logic [HASH_W-1:0]       sh_ff, sh_in;
   logic [IDX_W:0]          rem_ff, rem_in;
   logic [RED_CNT_W-1:0]    red_ff, red_in;
   logic                    done_ff, done_in;
   logic [BYTE_W-1:0]       cur_byte;
   logic [IDX_W:0]          rem_v;
   logic [HASH_W-1:0]       sh_v;

   assign cur_byte = key_ff[{cnt_ff[BYTE_IDX_W-1:0], 3'b000} +: BYTE_W];

   // restoring remainder, RED_BITS bits per cycle
   always_comb begin
      rem_v = rem_ff;
      sh_v  = sh_ff;
      for (int i = 0; i < RED_BITS; i++) begin
         rem_v = {rem_v[IDX_W-1:0], sh_v[HASH_W-1]};
         sh_v  = sh_v << 1;
         if (rem_v >= CAP_R) begin
            rem_v = rem_v - CAP_R;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      h_in     = h_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      red_in   = red_ff;
      done_in  = 1'b0;
      case (state_ff)
         HS_IDLE: begin
            if (start) begin
               key_in   = key;
               len_in   = key_len;
               cnt_in   = '0;
               h_in     = HASH_SEED;
               state_in = HS_BYTES;
            end
         end
         HS_BYTES: begin
            if (cnt_ff == len_ff) begin
               if (IS_POW2) begin
                  done_in  = 1'b1;
                  state_in = HS_IDLE;
               end else begin
                  sh_in    = h_ff;
                  rem_in   = '0;
                  red_in   = '0;
                  state_in = HS_REDUCE;
               end
            end else begin
               h_in   = (h_ff << HASH_SHIFT) + HASH_W'(cur_byte);
               cnt_in = cnt_ff + LEN_W'(1);
            end
         end
         HS_REDUCE: begin
            rem_in = rem_v;
            sh_in  = sh_v;
            red_in = red_ff + RED_CNT_W'(1);
            if (red_ff == RED_LAST) begin
               done_in  = 1'b1;
               state_in = HS_IDLE;
            end
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      key_ff <= key_in;
      len_ff <= len_in;
      cnt_ff <= cnt_in;
      h_ff   <= h_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      red_ff <= red_in;
   end

   assign done = done_ff;
   assign hash = h_ff;
   assign home = IS_POW2 ? h_ff[IDX_W-1:0] : rem_ff[IDX_W-1:0];
endmodule
`default_nettype wire

FILE: design/oaht_slot_mem.sv
// slot record memory, one write and one registered read port
`default_nettype none
module oaht_slot_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  oaht_pkg::slot_rec_type      wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output oaht_pkg::slot_rec_type      rd_data
);
   import oaht_pkg::*;

   slot_rec_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
